FILE: rtl/cse_pkg.sv
// shared types and constants for the can signal extractor
// no dependencies; used by every module of the block
package cse_pkg;

  localparam int FRAME_BYTES = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_START_BIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNEDNESS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MUX_LAYOUT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MUX_VALUE    = 3'd7;

  // bit field layout, size already clamped to 1..64
  typedef struct packed {
    logic [5:0] start;
    logic [6:0] size;
    logic       intel;
    logic       sgn;
  } field_cfg_t;

endpackage

FILE: rtl/cse_field_extract.sv
// two-stage bit field extractor: intel or motorola order, frame end cut, sign extend
// depends on cse_pkg
module cse_field_extract import cse_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  logic [63:0] data,
  input  logic [3:0] len,
  input  field_cfg_t fcfg,
  output logic [63:0] raw,
  output logic       hit
);

  logic [7:0]  msb;
  logic [4:0]  mbyte;
  logic [5:0]  fs;
  logic [6:0]  room;
  logic [6:0]  room_left;
  logic [6:0]  n_mot;
  logic [6:0]  n_c;
  logic [5:0]  lsh;
  logic [63:0] swapped;
  logic [63:0] src;
  logic        hit_c;
  logic        sgn_c;

  logic [63:0] shifted;
  logic [6:0]  n;
  logic        sgn;
  logic        hit1;

  logic [6:0]  rsh;
  logic [63:0] srl;
  logic [63:0] sra;

  // stage 1: align the field msb to bit 63
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      swapped[8*(7-k) +: 8] = data[8*k +: 8];
    end
  end

  assign msb       = {2'b00, fcfg.start} + {1'b0, fcfg.size} - 8'd1;
  assign mbyte     = fcfg.intel ? msb[7:3] : {2'b00, fcfg.start[5:3]};
  assign fs        = fcfg.start ^ 6'd7;
  assign room      = {len, 3'b000};
  assign room_left = room - {1'b0, fs};
  assign n_mot     = (room_left < fcfg.size) ? room_left : fcfg.size;
  assign n_c       = fcfg.intel ? fcfg.size : n_mot;
  assign lsh       = fcfg.intel ? ~msb[5:0] : fs;
  assign src       = fcfg.intel ? data : swapped;
  assign hit_c     = mbyte < {1'b0, len};
  assign sgn_c     = fcfg.sgn && (n_c == fcfg.size);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      shifted <= src << lsh;
      n       <= n_c;
      sgn     <= sgn_c;
      hit1    <= hit_c;
    end
  end

  // stage 2: bring the field down to bit 0
  assign rsh = 7'd64 - n;
  assign srl = shifted >> rsh[5:0];
  assign sra = $unsigned($signed(shifted) >>> rsh[5:0]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      raw <= hit1 ? (sgn ? sra : srl) : 64'd0;
      hit <= hit1;
    end
  end

endmodule

FILE: rtl/cse_scale.sv
// five-stage fixed point scaler: raw * q16.16 factor + q32.16 offset, saturated to 64 bits
// depends on cse_pkg
module cse_scale import cse_pkg::*; (
  input  logic        clk,
  input  logic [4:0]  en,
  input  logic [63:0] raw,
  input  logic        keep,
  input  logic [31:0] factor,
  input  logic [47:0] offset,
  output logic [63:0] value
);

  localparam logic [63:0] VALUE_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] VALUE_MIN = {1'b1, {63{1'b0}}};

  logic        fneg;
  logic [31:0] fmag;

  logic        rneg;
  logic [63:0] rmag;
  logic        keep3;

  logic [63:0] prod_lo;
  logic [63:0] prod_hi;
  logic        neg4;
  logic        keep4;

  logic [95:0] prod;
  logic        neg5;
  logic        keep5;

  logic [96:0] sprod;
  logic        keep6;

  logic [97:0] sum;
  logic        in_range;
  logic [63:0] sat;

  assign fneg = factor[31];
  assign fmag = fneg ? (32'd0 - factor) : factor;

  // stage 3: sign and magnitude of the raw value
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rneg  <= raw[63];
      rmag  <= raw[63] ? (64'd0 - raw) : raw;
      keep3 <= keep;
    end
  end

  // stage 4: two 32x32 partial products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_lo <= {32'd0, rmag[31:0]} * {32'd0, fmag};
      prod_hi <= {32'd0, rmag[63:32]} * {32'd0, fmag};
      neg4    <= rneg ^ fneg;
      keep4   <= keep3;
    end
  end

  // stage 5: combine partial products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod  <= {prod_hi, 32'd0} + {32'd0, prod_lo};
      neg5  <= neg4;
      keep5 <= keep4;
    end
  end

  // stage 6: apply sign
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sprod <= neg5 ? (97'd0 - {1'b0, prod}) : {1'b0, prod};
      keep6 <= keep5;
    end
  end

  // stage 7: offset and saturation
  assign sum      = {sprod[96], sprod} + {{50{offset[47]}}, offset};
  assign in_range = (&sum[97:63]) || (~|sum[97:63]);
  assign sat      = in_range ? sum[63:0] : (sum[97] ? VALUE_MIN : VALUE_MAX);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      value <= keep6 ? sat : 64'd0;
    end
  end

endmodule

FILE: rtl/can_signal_extractor_core.sv
// top level of the can signal extractor: config registers, pipeline control, output beat
// depends on cse_pkg, cse_field_extract, cse_scale
//
// Decodes one signal from one CAN frame per beat. A beat carries the payload and its
// byte count; the result beat carries the scaled Q48.16 value and a present flag that
// follows the optional multiplexor. The datapath is seven register stages deep, and a
// new frame can enter every cycle while the output is not stalled. Two stages extract
// the signal and multiplexor fields side by side, then the scaler spends five stages
// on the sign split, the two 32x32 partial products, their sum, the sign and the
// offset with saturation. Each stage only waits when it is full and the stage after
// it cannot take its beat, so bubbles close up while the output is stalled. The user
// must make config writes only while no frame is in flight; the block does not check it.
module can_signal_extractor_core import cse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [71:0]           s_tdata,   // frame_data[63:0], frame_length[67:64], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [63:0]           m_tdata,   // value[63:0]
  output logic                  m_tuser,   // present[0]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STAGES = 7;

  logic [5:0]  sig_start;
  logic [6:0]  bit_length;
  logic        byte_order;
  logic        signedness;
  logic [31:0] scale_factor;
  logic [47:0] scale_offset;
  logic [15:0] mux_layout;
  logic [31:0] mux_value;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;
  logic [STAGES-1:0] vld_in;

  logic [3:0]  frame_length;
  logic [3:0]  len_c;
  logic [6:0]  mux_len_m1;
  field_cfg_t  sig_cfg;
  field_cfg_t  mux_cfg;

  logic [63:0] sig_raw;
  logic        sig_hit;
  logic [63:0] mux_raw;
  logic        mux_hit;
  logic        present_c;
  logic        keep;

  logic [STAGES-3:0] present;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sig_start    <= 6'd0;
      bit_length   <= 7'd8;
      byte_order   <= 1'b1;
      signedness   <= 1'b0;
      scale_factor <= 32'd65536;
      scale_offset <= 48'd0;
      mux_layout   <= 16'd0;
      mux_value    <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BIT:    sig_start    <= cfg_data[5:0];
        REG_BIT_LENGTH:   bit_length   <= cfg_data[6:0];
        REG_BYTE_ORDER:   byte_order   <= cfg_data[0];
        REG_SIGNEDNESS:   signedness   <= cfg_data[0];
        REG_SCALE_FACTOR: scale_factor <= cfg_data[31:0];
        REG_SCALE_OFFSET: scale_offset <= cfg_data[47:0];
        REG_MUX_LAYOUT:   mux_layout   <= cfg_data[15:0];
        REG_MUX_VALUE:    mux_value    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  always_comb begin
    rdy[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int k = STAGES-2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld[STAGES-2:0], s_tvalid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[STAGES-1];

  // field layouts
  assign frame_length = s_tdata[67:64];
  assign len_c = (frame_length > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : frame_length;

  assign sig_cfg.start = sig_start;
  assign sig_cfg.size  = (bit_length == 7'd0) ? 7'd1 :
                         ((bit_length > 7'd64) ? 7'd64 : bit_length);
  assign sig_cfg.intel = byte_order;
  assign sig_cfg.sgn   = signedness;

  assign mux_len_m1    = mux_layout[8:2];
  assign mux_cfg.start = mux_layout[14:9];
  assign mux_cfg.size  = (mux_len_m1 >= 7'd63) ? 7'd64 : (mux_len_m1 + 7'd1);
  assign mux_cfg.intel = mux_layout[1];
  assign mux_cfg.sgn   = mux_layout[0];

  cse_field_extract u_sig (
    .clk  (clk),
    .en   (rdy[1:0]),
    .data (s_tdata[63:0]),
    .len  (len_c),
    .fcfg (sig_cfg),
    .raw  (sig_raw),
    .hit  (sig_hit)
  );

  cse_field_extract u_mux (
    .clk  (clk),
    .en   (rdy[1:0]),
    .data (s_tdata[63:0]),
    .len  (len_c),
    .fcfg (mux_cfg),
    .raw  (mux_raw),
    .hit  (mux_hit)
  );

  // a multiplexor beyond the frame already reads as zero
  assign present_c = !mux_layout[15] || (mux_raw == {32'd0, mux_value});
  assign keep      = present_c && sig_hit;

  cse_scale u_scale (
    .clk    (clk),
    .en     (rdy[STAGES-1:2]),
    .raw    (sig_raw),
    .keep   (keep),
    .factor (scale_factor),
    .offset (scale_offset),
    .value  (m_tdata)
  );

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      present[0] <= present_c;
    end
    for (int k = 1; k < STAGES-2; k++) begin
      if (rdy[k+2]) begin
        present[k] <= present[k-1];
      end
    end
  end

  assign m_tuser = present[STAGES-3];

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("value not cleared for an absent signal");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output stage");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted frame missing from the first stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    vld[STAGES-2] && !m_tvalid |=> m_tvalid)
    else $error("result did not advance into an empty output stage");

  a_mux_outside: assert property (@(posedge clk) disable iff (rst)
    !mux_hit |-> mux_raw == 64'd0)
    else $error("multiplexor outside the frame not read as zero");

endmodule
